[design/vnt_pkg.sv]
package vnt_pkg;

  // Fixed field formats
  localparam int NORM_W   = 16;
  localparam int MAT_W    = 16;
  localparam int MAT_FRAC = 12;
  localparam int NUM_ROWS = 4;
  localparam int ROW_W    = MAT_W * NUM_ROWS;

  // Normal datapath widths
  localparam int NPROD_W = 2 * NORM_W;
  localparam int T_W     = NPROD_W + 2;
  localparam int MAG_W   = T_W - 1;
  localparam int A_W     = 31;
  localparam int SQ_W    = 2 * A_W;
  localparam int LEN_W   = 64;
  localparam int ROOT_W  = LEN_W / 2;
  localparam int QUO_W   = 15;
  localparam int REM_W   = 47;
  localparam int LSH_W   = 5;
  localparam int MSB_W   = 6;

  // Pipeline depths
  localparam int POS_LAT   = 3;
  localparam int FRONT_LAT = 7;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int POS_DELAY = FRONT_LAT + SQRT_LAT + DIV_LAT - POS_LAT;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3
  } reg_idx_e;

  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] mat_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic       last;
  } nrm_side_t;

  typedef struct packed {
    logic [2:0][A_W-1:0] mag;
    nrm_side_t           side;
  } sqrt_side_t;

  // Signed Q4.12 entry of one matrix row
  function automatic logic signed [MAT_W-1:0] mat_entry(logic [ROW_W-1:0] row, int col);
    return $signed(row[MAT_W*col +: MAT_W]);
  endfunction

endpackage

[design/vnt_delay.sv]
module vnt_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  // Shift the payload one place per cycle
  always_ff @(posedge clk_i) begin
    line_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  assign data_o = line_q[DEPTH-1];

endmodule

[design/vnt_pos.sv]
module vnt_pos
  import vnt_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  mat_t                                mat_i,
  input  logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] pos_i,
  output logic                                valid_o,
  output logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] pos_o
);

  localparam int PW = COORD_WIDTH + MAT_W;
  localparam int SW = PW + 2;
  localparam int VW = SW - MAT_FRAC;
  localparam logic signed [SW-1:0] RND = SW'(1 << (MAT_FRAC - 1));
  localparam logic signed [VW-1:0] CMAX = {{(VW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [VW-1:0] CMIN = ~CMAX;

  logic signed [PW-1:0] prod_q [NUM_ROWS][NUM_ROWS];
  logic signed [SW-1:0] sum_d [NUM_ROWS];
  logic signed [SW-1:0] sum_q [NUM_ROWS];
  logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] sat_d, sat_q;
  logic [POS_LAT-1:0] v_q;

  // Stage 1: one product per matrix entry
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        prod_q[r][c] <= mat_entry(mat_i[r], c) * $signed(pos_i[c]);
      end
    end
  end

  // Stage 2: exact row sums with the rounding half added
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_d[r] = RND;
      for (int c = 0; c < NUM_ROWS; c++) begin
        sum_d[r] = sum_d[r] + SW'(prod_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Stage 3: drop the fraction and saturate
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      logic signed [VW-1:0] v;
      v = VW'(sum_q[r] >>> MAT_FRAC);
      if (v > CMAX) begin
        sat_d[r] = CMAX[COORD_WIDTH-1:0];
      end else if (v < CMIN) begin
        sat_d[r] = CMIN[COORD_WIDTH-1:0];
      end else begin
        sat_d[r] = v[COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[POS_LAT-2:0], valid_i};
    end
  end

  assign valid_o = v_q[POS_LAT-1];
  assign pos_o   = sat_q;

endmodule

[design/vnt_nfront.sv]
module vnt_nfront
  import vnt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  mat_t                   mat_i,
  input  logic [2:0][NORM_W-1:0] norm_i,
  input  logic                   last_i,
  output logic                   valid_o,
  output logic [LEN_W-1:0]       len2_o,
  output sqrt_side_t             side_o
);

  logic signed [NPROD_W-1:0] nprod_q [3][3];
  logic signed [T_W-1:0]     t_q [3];
  logic [2:0][MAG_W-1:0]     mag3_q, mag4_q;
  logic [2:0][A_W-1:0]       a5_q, a6_q, a7_q;
  logic [SQ_W-1:0]           sq_q [3];
  logic [LEN_W-1:0]          len2_q;
  nrm_side_t                 side_q [2:FRONT_LAT];
  logic [FRONT_LAT-1:0]      v_q;
  logic                      last1_q;
  logic [MAG_W-1:0]          orv;
  logic [MSB_W-1:0]          msb;
  logic                      rsh_q;
  logic [LSH_W-1:0]          lsh_q;

  // Stage 1: products of the upper-left 3x3 and the normal
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nprod_q[r][c] <= mat_entry(mat_i[r], c) * $signed(norm_i[c]);
      end
    end
    last1_q <= last_i;
  end

  // Stage 2: row sums
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      t_q[r] <= T_W'(nprod_q[r][0]) + T_W'(nprod_q[r][1]) + T_W'(nprod_q[r][2]);
    end
    side_q[2] <= '{neg: '0, zero: 1'b0, last: last1_q};
  end

  // Stage 3: sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      logic signed [T_W-1:0] m;
      m = (t_q[r] < 0) ? -t_q[r] : t_q[r];
      mag3_q[r]         <= m[MAG_W-1:0];
      side_q[3].neg[r]  <= t_q[r] < 0;
    end
    side_q[3].zero <= (t_q[0] == '0) && (t_q[1] == '0) && (t_q[2] == '0);
    side_q[3].last <= side_q[2].last;
  end

  // Stage 4: common shift from the leading one of the largest magnitude
  always_comb begin
    orv = mag3_q[0] | mag3_q[1] | mag3_q[2];
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) begin
        msb = MSB_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsh_q     <= orv[MAG_W-1] | orv[MAG_W-2];
    lsh_q     <= (msb > MSB_W'(A_W - 1)) ? '0 : LSH_W'(MSB_W'(A_W - 1) - msb);
    mag4_q    <= mag3_q;
    side_q[4] <= side_q[3];
  end

  // Stage 5: normalize so the largest lies in [2^30, 2^31)
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      logic [MAG_W-1:0] sh;
      sh = rsh_q ? (mag4_q[r] >> 1) : (mag4_q[r] << lsh_q);
      a5_q[r] <= sh[A_W-1:0];
    end
    side_q[5] <= side_q[4];
  end

  // Stage 6: squares
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      sq_q[r] <= a5_q[r] * a5_q[r];
    end
    a6_q      <= a5_q;
    side_q[6] <= side_q[5];
  end

  // Stage 7: squared length
  always_ff @(posedge clk_i) begin
    len2_q    <= LEN_W'(sq_q[0]) + LEN_W'(sq_q[1]) + LEN_W'(sq_q[2]);
    a7_q      <= a6_q;
    side_q[7] <= side_q[6];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FRONT_LAT-2:0], valid_i};
    end
  end

  assign valid_o     = v_q[FRONT_LAT-1];
  assign len2_o      = len2_q;
  assign side_o.mag  = a7_q;
  assign side_o.side = side_q[FRONT_LAT];

  // A nonzero normal leaves the normalizer with bit 30 of the largest set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !side_q[5].zero) |-> ((a5_q[0] | a5_q[1] | a5_q[2]) >> (A_W - 1)) == 1)
    else $error("normalized magnitude out of range");

endmodule

[design/vnt_sqrt.sv]
module vnt_sqrt
  import vnt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [LEN_W-1:0]  x_i,
  input  sqrt_side_t        side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sqrt_side_t        side_o
);

  localparam int N = SQRT_LAT;

  logic [LEN_W-1:0] x_q   [N+1];
  logic [LEN_W-1:0] res_q [N+1];
  sqrt_side_t       side_q [N+1];
  logic [N:0]       v_q;

  assign x_q[0]    = x_i;
  assign res_q[0]  = '0;
  assign side_q[0] = side_i;
  assign v_q[0]    = valid_i;

  // One result bit per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [LEN_W-1:0] BIT = LEN_W'(1) << (LEN_W - 2 - 2 * k);
    logic [LEN_W-1:0] trial;

    assign trial = res_q[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (x_q[k] >= trial) begin
        x_q[k+1]   <= x_q[k] - trial;
        res_q[k+1] <= (res_q[k] >> 1) + BIT;
      end else begin
        x_q[k+1]   <= x_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
      side_q[k+1] <= side_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign valid_o = v_q[N];
  assign root_o  = (res_q[N] == '0) ? ROOT_W'(1) : res_q[N][ROOT_W-1:0];
  assign side_o  = side_q[N];

  // A normalized length is at least 2^30
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.side.zero) |-> (root_o[ROOT_W-1:ROOT_W-2] != 2'b00))
    else $error("square root below normalized range");

endmodule

[design/vnt_div.sv]
module vnt_div
  import vnt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  sqrt_side_t            side_i,
  output logic                  valid_o,
  output logic [2:0][QUO_W-1:0] quo_o,
  output nrm_side_t             side_o
);

  localparam int N = QUO_W;

  logic [2:0][REM_W-1:0] rem_q [N+1];
  logic [2:0][QUO_W-1:0] quo_q [N+1];
  logic [ROOT_W-1:0]     den_q [N+1];
  nrm_side_t             side_q [N+1];
  logic [N:0]            v_q;

  // Prepare numerators a * 2^14 + floor(s / 2)
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      rem_q[0][l] <= (REM_W'(side_i.mag[l]) << (QUO_W - 1)) + REM_W'(root_i >> 1);
    end
    quo_q[0]  <= '0;
    den_q[0]  <= root_i;
    side_q[0] <= side_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  // Restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [REM_W-1:0] dsh;

    assign dsh = REM_W'(den_q[j]) << (N - 1 - j);

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        if (rem_q[j][l] >= dsh) begin
          rem_q[j+1][l] <= rem_q[j][l] - dsh;
          quo_q[j+1][l] <= {quo_q[j][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[j+1][l] <= rem_q[j][l];
          quo_q[j+1][l] <= {quo_q[j][l][QUO_W-2:0], 1'b0};
        end
      end
      den_q[j+1]  <= den_q[j];
      side_q[j+1] <= side_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end
  end

  assign valid_o = v_q[N];
  assign quo_o   = quo_q[N];
  assign side_o  = side_q[N];

  // A unit component never exceeds 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !side_o.zero) |->
      (quo_o[0] <= QUO_W'(16384) && quo_o[1] <= QUO_W'(16384) && quo_o[2] <= QUO_W'(16384)))
    else $error("unit component above one");

endmodule

[design/vertex_normal_transform.sv]
// Vertex transform: takes one vertex per clock (busy is always low) and
// returns the results in order, each marked by result_valid_o for one
// cycle; the receiver cannot stall. The depth is set by the normal path:
// a 7-stage multiply and normalize front, a 32-stage square root (one root
// bit per stage) and a 16-stage divider (a numerator stage, then one
// quotient bit per stage, three lanes). The position path is 3 stages and
// is delayed to match. Matrix rows are written through the cfg port (always
// ready, indexes above 3 ignored); the user must do so only while no vertex
// is in flight (not enforced by the block); reset loads the identity matrix.
module vertex_normal_transform
  import vnt_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [ROW_W-1:0]              cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] pos_w_i,
  input  logic signed [NORM_W-1:0]      norm_x_i,
  input  logic signed [NORM_W-1:0]      norm_y_i,
  input  logic signed [NORM_W-1:0]      norm_z_i,
  input  logic                          last_vertex_i,
  output logic                          result_valid_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic signed [COORD_WIDTH-1:0] out_w_o,
  output logic signed [NORM_W-1:0]      unit_x_o,
  output logic signed [NORM_W-1:0]      unit_y_o,
  output logic signed [NORM_W-1:0]      unit_z_o,
  output logic                          zero_normal_o,
  output logic                          end_of_batch_o
);

  localparam int PVW = NUM_ROWS * COORD_WIDTH;

  mat_t                                 mat_q;
  logic                                 accept;
  logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] pos_in, pos_res, pos_dly;
  logic                                 pos_valid;
  logic                                 front_valid, sqrt_valid, div_valid;
  logic [LEN_W-1:0]                     len2;
  sqrt_side_t                           front_side, sqrt_side;
  logic [ROOT_W-1:0]                    root;
  logic [2:0][QUO_W-1:0]                quo;
  nrm_side_t                            div_side;
  logic                                 res_valid_q;
  logic [NUM_ROWS-1:0][COORD_WIDTH-1:0] out_q;
  logic [2:0][NORM_W-1:0]               unit_q;
  logic                                 zero_q, last_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Matrix row registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        mat_q[r] <= ROW_W'(1) << (MAT_FRAC + MAT_W * r);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW0: mat_q[0] <= cfg_data_i;
        REG_ROW1: mat_q[1] <= cfg_data_i;
        REG_ROW2: mat_q[2] <= cfg_data_i;
        REG_ROW3: mat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pos_in = {pos_w_i, pos_z_i, pos_y_i, pos_x_i};

  vnt_pos #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .mat_i  (mat_q),
    .pos_i  (pos_in),
    .valid_o(pos_valid),
    .pos_o  (pos_res)
  );

  // Hold positions until the matching normal is done
  vnt_delay #(
    .WIDTH(PVW),
    .DEPTH(POS_DELAY)
  ) u_pos_dly (
    .clk_i (clk_i),
    .data_i(pos_res),
    .data_o(pos_dly)
  );

  vnt_nfront u_nfront (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .mat_i  (mat_q),
    .norm_i ({norm_z_i, norm_y_i, norm_x_i}),
    .last_i (last_vertex_i),
    .valid_o(front_valid),
    .len2_o (len2),
    .side_o (front_side)
  );

  vnt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(front_valid),
    .x_i    (len2),
    .side_i (front_side),
    .valid_o(sqrt_valid),
    .root_o (root),
    .side_o (sqrt_side)
  );

  vnt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sqrt_valid),
    .root_i (root),
    .side_i (sqrt_side),
    .valid_o(div_valid),
    .quo_o  (quo),
    .side_o (div_side)
  );

  // Result register: apply signs, zero out a zero-length normal
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      logic [NORM_W-1:0] u;
      u = NORM_W'(quo[l]);
      if (div_side.zero) begin
        unit_q[l] <= '0;
      end else begin
        unit_q[l] <= div_side.neg[l] ? (NORM_W'(0) - u) : u;
      end
    end
    out_q  <= pos_dly;
    zero_q <= div_side.zero;
    last_q <= div_side.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_valid;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_x_o        = out_q[0];
  assign out_y_o        = out_q[1];
  assign out_z_o        = out_q[2];
  assign out_w_o        = out_q[3];
  assign unit_x_o       = unit_q[0];
  assign unit_y_o       = unit_q[1];
  assign unit_z_o       = unit_q[2];
  assign zero_normal_o  = zero_q;
  assign end_of_batch_o = last_q;

  // The position and normal paths stay aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_valid |-> ##(POS_DELAY) div_valid)
    else $error("position and normal paths out of step");

endmodule
